// ===== design/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// Archive stream decryptor package
// Shared result codes, key constants and the types passed between stages.
// ----------------------------------------------------------------------------
package asd_pkg;

   // Result kinds carried on the result channel's tuser.
   localparam logic [2:0] KIND_NAME    = 3'd0;
   localparam logic [2:0] KIND_CONTENT = 3'd1;
   localparam logic [2:0] KIND_NAMELEN = 3'd2;
   localparam logic [2:0] KIND_SIZE    = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   // Reset value of the start key register.
   localparam logic [31:0] START_KEY_RESET = 32'hDEADCAFE;

   // One input word as held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
      logic       archive_start;
   } item_type;

   // One result word as produced by the core and held in the output register.
   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } result_type;

endpackage

// ===== design/asd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Archive stream decryptor input stage
// Registers one incoming word and hands it to the core when it advances.
// ----------------------------------------------------------------------------
module asd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_byte,
   input  logic              req_start,
   input  logic              advance,
   output asd_pkg::item_type item
);
   import asd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       load;

   // The register can take a word when empty or when its word moves on now.
   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   // Occupancy follows loads and departures.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= req_byte;
         start_ff <= req_start;
      end
   end

   assign item.valid         = valid_ff;
   assign item.in_byte       = byte_ff;
   assign item.archive_start = start_ff;

endmodule

// ===== design/asd_core.sv =====
// ----------------------------------------------------------------------------
// Archive stream decryptor core
// Holds parser and key state and decodes one archive byte per advance.
// ----------------------------------------------------------------------------
module asd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  asd_pkg::item_type   item,
   input  logic                advance,
   output asd_pkg::result_type result
);
   import asd_pkg::*;

   // Parser phase codes.
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_NAMELEN = 3'd1;
   localparam logic [2:0] PH_NAME    = 3'd2;
   localparam logic [2:0] PH_SIZE    = 3'd3;
   localparam logic [2:0] PH_CONTENT = 3'd4;
   localparam logic [2:0] PH_HOLD    = 3'd5;

   // Expected archive signature byte at a given header position.
   function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = 8'h52;
         3'd1:    b = 8'h47;
         3'd2:    b = 8'h53;
         3'd3:    b = 8'h53;
         3'd4:    b = 8'h41;
         3'd5:    b = 8'h44;
         3'd6:    b = 8'h00;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

   // Key step: key * 7 + 3, written as shift, subtract and add.
   function automatic logic [31:0] next_key(input logic [31:0] k);
      return (k << 3) - k + 32'd3;
   endfunction

   logic [31:0] start_key_ff;
   logic [2:0]  phase_ff,   phase_in;
   logic [2:0]  count_ff,   count_in;
   logic [31:0] run_key_ff, run_key_in;
   logic [31:0] con_key_ff, con_key_in;
   logic [1:0]  kidx_ff,    kidx_in;
   logic [31:0] shift_ff,   shift_in;
   logic [31:0] remain_ff,  remain_in;

   logic [2:0]  phase_cur;
   logic [2:0]  count_cur;
   logic [31:0] run_key_cur;
   logic [31:0] con_key_cur;
   logic [1:0]  kidx_cur;
   logic [31:0] shift_cur;
   logic [31:0] remain_cur;
   logic [31:0] shift_new;
   logic [31:0] word;
   logic [31:0] remain_dec;
   logic [31:0] con_shifted;
   logic [7:0]  b;

   // Start key register; the user must write it only while the block is idle, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_key_ff <= START_KEY_RESET;
      end else if (csr_wr_en) begin
         start_key_ff <= csr_wr_data;
      end
   end

   // Decode of one byte against the current state.
   always_comb begin
      b = item.in_byte;

      // A start flag restarts the parser before the byte is used.
      if (item.archive_start) begin
         phase_cur   = PH_HEADER;
         count_cur   = 3'd0;
         run_key_cur = start_key_ff;
         con_key_cur = 32'd0;
         kidx_cur    = 2'd0;
         shift_cur   = 32'd0;
         remain_cur  = 32'd0;
      end else begin
         phase_cur   = phase_ff;
         count_cur   = count_ff;
         run_key_cur = run_key_ff;
         con_key_cur = con_key_ff;
         kidx_cur    = kidx_ff;
         shift_cur   = shift_ff;
         remain_cur  = remain_ff;
      end

      phase_in   = phase_cur;
      count_in   = count_cur;
      run_key_in = run_key_cur;
      con_key_in = con_key_cur;
      kidx_in    = kidx_cur;
      shift_in   = shift_cur;
      remain_in  = remain_cur;

      shift_new   = shift_cur | ({24'd0, b} << {count_cur[1:0], 3'b000});
      word        = shift_new ^ run_key_cur;
      remain_dec  = remain_cur - 32'd1;
      con_shifted = con_key_cur >> {kidx_cur, 3'b000};

      result.valid = 1'b0;
      result.kind  = KIND_ERROR;
      result.value = 32'd0;
      result.last  = 1'b0;

      case (phase_cur)
         PH_HEADER: begin
            if (b != hdr_byte(count_cur)) begin
               // Bad signature: one error word, then hold until a restart.
               phase_in     = PH_HOLD;
               count_in     = 3'd0;
               result.valid = 1'b1;
               result.kind  = KIND_ERROR;
               result.last  = 1'b1;
            end else if (count_cur == 3'd7) begin
               count_in = 3'd0;
               shift_in = 32'd0;
               phase_in = PH_NAMELEN;
            end else begin
               count_in = count_cur + 3'd1;
            end
         end
         PH_NAMELEN, PH_SIZE: begin
            if (count_cur[1:0] != 2'd3) begin
               shift_in = shift_new;
               count_in = count_cur + 3'd1;
            end else begin
               // Full length word: decrypt with the whole running key.
               count_in     = 3'd0;
               shift_in     = 32'd0;
               run_key_in   = next_key(run_key_cur);
               remain_in    = word;
               result.valid = 1'b1;
               result.value = word;
               if (phase_cur == PH_NAMELEN) begin
                  result.kind = KIND_NAMELEN;
                  phase_in    = (word == 32'd0) ? PH_SIZE : PH_NAME;
               end else begin
                  result.kind = KIND_SIZE;
                  con_key_in  = next_key(run_key_cur);
                  kidx_in     = 2'd0;
                  phase_in    = (word == 32'd0) ? PH_NAMELEN : PH_CONTENT;
               end
            end
         end
         PH_NAME: begin
            run_key_in   = next_key(run_key_cur);
            remain_in    = remain_dec;
            result.valid = 1'b1;
            result.kind  = KIND_NAME;
            result.value = {24'd0, b ^ run_key_cur[7:0]};
            result.last  = (remain_dec == 32'd0);
            if (remain_dec == 32'd0) begin
               phase_in = PH_SIZE;
            end
         end
         PH_CONTENT: begin
            // Content key advances after each group of four bytes.
            kidx_in = kidx_cur + 2'd1;
            if (kidx_cur == 2'd3) begin
               con_key_in = next_key(con_key_cur);
            end
            remain_in    = remain_dec;
            result.valid = 1'b1;
            result.kind  = KIND_CONTENT;
            result.value = {24'd0, b ^ con_shifted[7:0]};
            result.last  = (remain_dec == 32'd0);
            if (remain_dec == 32'd0) begin
               phase_in = PH_NAMELEN;
            end
         end
         default: begin
            // Hold and unused codes ignore every byte.
         end
      endcase

      if (!advance) begin
         result.valid = 1'b0;
      end
   end

   // Parser state, updated once per consumed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= 3'd0;
         kidx_ff  <= 2'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         kidx_ff  <= kidx_in;
      end
   end

   // Keys and counters follow the reset values of the parser as well.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_key_ff <= START_KEY_RESET;
         con_key_ff <= 32'd0;
         shift_ff   <= 32'd0;
         remain_ff  <= 32'd0;
      end else if (advance) begin
         run_key_ff <= run_key_in;
         con_key_ff <= con_key_in;
         shift_ff   <= shift_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

// ===== design/asd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Archive stream decryptor output stage
// Result register that holds a decoded word until the consumer takes it.
// ----------------------------------------------------------------------------
module asd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  asd_pkg::result_type result,
   input  logic                item_valid,
   output logic                advance,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_value,
   output logic [2:0]          rsp_kind,
   output logic                rsp_last
);
   import asd_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] value_ff;
   logic [2:0]  kind_ff;
   logic        last_ff;

   // The core moves on when it holds a word and the result slot is free or emptying now.
   assign advance = item_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result.valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded only with a fresh result.
   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         value_ff <= result.value;
         kind_ff  <= result.kind;
         last_ff  <= result.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== design/archive_stream_decryptor.sv =====
// ----------------------------------------------------------------------------
// Archive stream decryptor
// Checks the archive signature and decrypts length words, names and content.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                      Contents
// req       in         req_tvalid/tready/tdata    tdata[7:0] archive byte,
//                      req_tuser                  tuser[0] archive start
// rsp       out        rsp_tvalid/tready/tdata    tdata[31:0] decoded value,
//                      rsp_tuser, rsp_tlast       tuser[2:0] kind, tlast run end
// csr       in         csr_wr_en, csr_wr_data     start key
//
// One byte is accepted every cycle while the result channel does not stall;
// its result passes through the input register and then the result register.
// The key update and remaining-count decrement fit in the single core stage.
// Reset is synchronous and active high; no clearing pass is needed.
// A stalled result holds the core and, through it, the input register.
// ----------------------------------------------------------------------------
module archive_stream_decryptor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] archive_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [2:0]  rsp_tuser,   // [2:0] out_kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import asd_pkg::*;

   item_type   item;
   result_type result;
   logic       advance;

   // Input register.
   asd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_start  (req_tuser[0]),
      .advance    (advance),
      .item       (item)
   );

   // Parser, key state and decryption.
   asd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .advance     (advance),
      .result      (result)
   );

   // Result register.
   asd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .item_valid (item.valid),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_kind   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // A signature error always carries a zero value and ends its run.
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tlast && rsp_tdata == 32'd0)
      else $error("error result with wrong value or last flag");

   // Length words never mark the end of a run.
   a_length_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_NAMELEN || rsp_tuser == KIND_SIZE)
      |-> !rsp_tlast)
      else $error("length word flagged as last");

   // Byte results carry only an eight-bit value.
   a_byte_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_NAME || rsp_tuser == KIND_CONTENT)
      |-> rsp_tdata[31:8] == 24'd0)
      else $error("byte result wider than eight bits");

   // No kind beyond the error code is produced.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= KIND_ERROR)
      else $error("result kind out of range");
`endif

endmodule
